// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the channel tuning block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define CHTW_ASSERT_ALWAYS(LABEL, CLK, RSTN, EXPR) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (EXPR)) \
        else $error("assertion failed: invariant");

// When the antecedent holds, the consequent holds in the same cycle.
`define CHTW_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("assertion failed: implication");

`else

`define CHTW_ASSERT_ALWAYS(LABEL, CLK, RSTN, EXPR)
`define CHTW_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS)

`endif

`endif

// ===== hdl/chtw_pkg.sv =====
// Types, constants and the offset look-up table of the channel tuning block.
`default_nettype none

package chtw_pkg;

    localparam int CHAN_W      = 7;
    localparam int OFF_W       = 6;
    localparam int FREQ_W      = 30;
    localparam int WORD_W      = 16;
    localparam int MHZ_W       = 10;
    localparam int REM_W       = 20;
    localparam int FRAC_BITS   = 6;
    localparam int STEP_BITS   = 3;

    localparam int ONE_MHZ     = 1000000;
    localparam int SEVENTH_MHZ = 142857;
    localparam int ROUND_LIMIT = 7812;
    localparam int HIGH_BAND_MHZ = 333;

    // The offset table returns its whole-MHz part biased by this amount so that it stays
    // non-negative; the base frequency carries the matching negative bias.
    localparam int MHZ_BIAS    = 5;
    localparam int BASE_MHZ    = 93 - MHZ_BIAS;
    localparam int CHAN_STEP_MHZ = 6;

    localparam int BAND_LO_FIRST = 12;
    localparam int BAND_LO_LAST  = 16;
    localparam int UPPER_SPLIT   = 62;

    localparam int OFF_ENTRIES = 1 << OFF_W;

    typedef struct packed {
        logic [3:0]       mhz;
        logic [REM_W-1:0] rem;
    } off_entry_t;

    typedef off_entry_t [OFF_ENTRIES-1:0] off_tab_t;

    // Splits 142857 Hz plus the truncated offset into whole MHz and a remainder.
    function automatic off_tab_t build_off_tab();
        off_tab_t tab;
        int       off;
        int       s;
        tab = '0;
        for (int i = 0; i < OFF_ENTRIES; i++)
        begin
            off = (i < OFF_ENTRIES / 2) ? i : i - OFF_ENTRIES;
            s = SEVENTH_MHZ + (off * ONE_MHZ) / 7 + MHZ_BIAS * ONE_MHZ;
            tab[i].mhz = 4'(s / ONE_MHZ);
            tab[i].rem = REM_W'(s % ONE_MHZ);
        end
        return tab;
    endfunction

    localparam off_tab_t OFF_TAB = build_off_tab();

endpackage

`default_nettype wire

// ===== hdl/chtw_frac_steps.sv =====
// Three consecutive fraction bits of the tuning word by halving compare and subtract.
`default_nettype none

module chtw_frac_steps
    import chtw_pkg::*;
#(
    parameter int FIRST_STEP = 0
)
(
    input  wire logic [REM_W-1:0]     rem_in,
    output logic      [REM_W-1:0]     rem_out,
    output logic      [STEP_BITS-1:0] bits
);

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] div;
        r    = rem_in;
        bits = '0;
        for (int k = 0; k < STEP_BITS; k++)
        begin
            div = REM_W'(ONE_MHZ >> (FIRST_STEP + k + 1));
            // The compare is strict: a remainder equal to the divider gives a zero bit.
            if (r > div)
            begin
                r = r - div;
                bits[STEP_BITS-1-k] = 1'b1;
            end
        end
        rem_out = r;
    end

endmodule

`default_nettype wire

// ===== hdl/channel_to_tuning_word_core.sv =====
// Top level of the channel to tuning word converter: three-stage pipeline.
`default_nettype none
`include "assert_macros.svh"

// Each word carries a channel number and an offset in 1/7 MHz steps and yields the RF
// frequency in hertz, the 16-bit synthesizer tuning word and a high-band flag. The pipeline
// takes one word per cycle while req_stall is low; a word moves through three register
// stages (offset table and MHz sum, MHz product with the first three fraction bits, final
// sum with the last three fraction bits and rounding), and the last of them drives the outputs.
// A stall at the output holds the result; stages that hold no word keep filling, so input
// words are still taken until all three stages are occupied. Channels above MAX_CHANNEL
// flag channel_invalid and give zero in every other field.
module channel_to_tuning_word_core
    import chtw_pkg::*;
#(
    parameter int MAX_CHANNEL = 112
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic [CHAN_W-1:0]       channel,
    input  wire logic signed [OFF_W-1:0] freq_offset,

    output logic                         res_valid,
    input  wire logic                    res_stall,
    output logic                         channel_invalid,
    output logic [FREQ_W-1:0]            freq_hz,
    output logic [WORD_W-1:0]            tune_word,
    output logic                         high_band
);

    // Stage enables: a stage loads when it is empty or its successor moves on.
    logic en1;
    logic en2;
    logic en3;

    // Stage 1 registers.
    logic             v1_reg;
    logic             inv1_reg;
    logic [MHZ_W-1:0] mhz1_reg;
    logic [REM_W-1:0] rem1_reg;

    // Stage 2 registers.
    logic                 v2_reg;
    logic                 inv2_reg;
    logic [MHZ_W-1:0]     mhz2_reg;
    logic [REM_W-1:0]     rem2_reg;
    logic [REM_W-1:0]     rem3_reg;
    logic [STEP_BITS-1:0] frac_hi_reg;
    logic [FREQ_W-1:0]    prod_reg;
    logic                 band2_reg;

    // Output registers.
    logic              res_valid_reg;
    logic              inv_out_reg;
    logic [FREQ_W-1:0] freq_out_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic              band_out_reg;

    // Next values.
    logic                 inv1_next;
    logic [MHZ_W-1:0]     mhz1_next;
    logic [REM_W-1:0]     rem1_next;
    logic [REM_W-1:0]     rem3_next;
    logic [STEP_BITS-1:0] frac_hi_next;
    logic [FREQ_W-1:0]    prod_next;
    logic                 band2_next;
    logic [REM_W-1:0]     rem6;
    logic [STEP_BITS-1:0] frac_lo;
    logic [FREQ_W-1:0]    freq_out_next;
    logic [WORD_W-1:0]    word_out_next;

    off_entry_t off_entry;
    logic       extra_band;

    assign en3 = !res_valid_reg || !res_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign req_stall = !en1;

    // Stage 1: offset table and whole-MHz sum.
    assign off_entry  = OFF_TAB[$unsigned(freq_offset)];
    assign extra_band = ((channel >= CHAN_W'(BAND_LO_FIRST)) && (channel <= CHAN_W'(BAND_LO_LAST)))
                        || (channel > CHAN_W'(UPPER_SPLIT));
    assign inv1_next  = channel > CHAN_W'(MAX_CHANNEL);
    assign mhz1_next  = MHZ_W'(BASE_MHZ)
                        + MHZ_W'(channel) * MHZ_W'(CHAN_STEP_MHZ)
                        + {{(MHZ_W-2){1'b0}}, extra_band, 1'b0}
                        + MHZ_W'(off_entry.mhz);
    assign rem1_next  = off_entry.rem;

    // Stage 2: MHz scaled to hertz and the first three fraction bits.
    assign prod_next  = FREQ_W'(mhz1_reg) * FREQ_W'(ONE_MHZ);
    assign band2_next = mhz1_reg >= MHZ_W'(HIGH_BAND_MHZ);

    chtw_frac_steps #(
        .FIRST_STEP(0)
    ) u_frac_hi (
        .rem_in  (rem1_reg),
        .rem_out (rem3_next),
        .bits    (frac_hi_next)
    );

    // Stage 3: final sum, last three fraction bits and the round-up.
    chtw_frac_steps #(
        .FIRST_STEP(STEP_BITS)
    ) u_frac_lo (
        .rem_in  (rem3_reg),
        .rem_out (rem6),
        .bits    (frac_lo)
    );

    always_comb
    begin
        freq_out_next = prod_reg + FREQ_W'(rem2_reg);
        word_out_next = {mhz2_reg, frac_hi_reg, frac_lo}
                        + WORD_W'(rem6 > REM_W'(ROUND_LIMIT));
        if (inv2_reg)
        begin
            freq_out_next = '0;
            word_out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                res_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            inv1_reg <= inv1_next;
            mhz1_reg <= mhz1_next;
            rem1_reg <= rem1_next;
        end
        if (en2)
        begin
            inv2_reg    <= inv1_reg;
            mhz2_reg    <= mhz1_reg;
            rem2_reg    <= rem1_reg;
            rem3_reg    <= rem3_next;
            frac_hi_reg <= frac_hi_next;
            prod_reg    <= prod_next;
            band2_reg   <= band2_next;
        end
        if (en3)
        begin
            inv_out_reg  <= inv2_reg;
            freq_out_reg <= freq_out_next;
            word_out_reg <= word_out_next;
            band_out_reg <= band2_reg && !inv2_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign channel_invalid = inv_out_reg;
    assign freq_hz         = freq_out_reg;
    assign tune_word       = word_out_reg;
    assign high_band       = band_out_reg;

    `CHTW_ASSERT_IMPL(a_stall_means_full, clk, rst_n, req_stall, v1_reg && v2_reg && res_valid_reg)
    `CHTW_ASSERT_IMPL(a_invalid_zero, clk, rst_n, res_valid && channel_invalid, (freq_hz == '0) && (tune_word == '0) && !high_band)
    `CHTW_ASSERT_IMPL(a_band_matches_freq, clk, rst_n, res_valid && !channel_invalid, high_band == (freq_hz >= FREQ_W'(HIGH_BAND_MHZ * ONE_MHZ)))
    `CHTW_ASSERT_IMPL(a_freq_range, clk, rst_n, res_valid && !channel_invalid, (freq_hz >= FREQ_W'(88000000)) && (freq_hz < FREQ_W'(870000000)))

endmodule

`default_nettype wire

// ===== verif/tb_channel_to_tuning_word_core.sv =====
// Self-checking testbench of the channel to tuning word pipeline.
`default_nettype none

module tb_channel_to_tuning_word_core
    import chtw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHANNEL = 112;

    localparam longint BASE_HZ       = 93000000;
    localparam longint SEVENTH_HZ    = 142857;
    localparam longint CHAN_STEP_HZ  = 6000000;
    localparam longint BAND_EXTRA_HZ = 2000000;
    localparam longint MHZ_HZ        = 1000000;
    localparam longint ROUND_HZ      = 7812;
    localparam longint HIGH_BAND_HZ  = 333000000;
    localparam int     LOW_BAND_FIRST = 12;
    localparam int     LOW_BAND_LAST  = 16;
    localparam int     UPPER_CHANNEL  = 62;

    localparam int RANDOM_WORDS = 1200;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct packed {
        logic              chan_invalid;
        logic [FREQ_W-1:0] freq_hz;
        logic [WORD_W-1:0] tune_word;
        logic              high_band;
    } tuning_t;

    typedef struct packed {
        logic [CHAN_W-1:0]       ch;
        logic signed [OFF_W-1:0] off;
        logic                    typed;
        tuning_t                 known;
    } stim_row_t;

    // Rows with typed set carry the result written out by hand; the others use the predictor.
    localparam int DIRECTED_ROWS = 22;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{7'd0,   6'sd0,   1'b1, '{1'b0, 30'd93142857,  16'd5961,  1'b0}},
        '{7'd112, 6'sd0,   1'b1, '{1'b0, 30'd767142857, 16'd49097, 1'b1}},
        '{7'd113, 6'sd0,   1'b1, '{1'b1, 30'd0,         16'd0,     1'b0}},
        '{7'd127, 6'sd31,  1'b1, '{1'b1, 30'd0,         16'd0,     1'b0}},
        '{7'd127, -6'sd32, 1'b1, '{1'b1, 30'd0,         16'd0,     1'b0}},
        '{7'd40,  -6'sd1,  1'b1, '{1'b0, 30'd333000000, 16'd21312, 1'b1}},
        '{7'd0,   -6'sd32, 1'b0, '0},
        '{7'd0,   6'sd31,  1'b0, '0},
        '{7'd112, 6'sd31,  1'b0, '0},
        '{7'd112, -6'sd32, 1'b0, '0},
        '{7'd11,  6'sd0,   1'b0, '0},
        '{7'd12,  6'sd0,   1'b0, '0},
        '{7'd16,  6'sd0,   1'b0, '0},
        '{7'd17,  6'sd0,   1'b0, '0},
        '{7'd62,  6'sd0,   1'b0, '0},
        '{7'd63,  6'sd0,   1'b0, '0},
        '{7'd40,  -6'sd2,  1'b0, '0},
        '{7'd39,  6'sd5,   1'b0, '0},
        '{7'd20,  -6'sd7,  1'b0, '0},
        '{7'd20,  6'sd7,   1'b0, '0},
        '{7'd64,  -6'sd21, 1'b0, '0},
        '{7'd85,  6'sd21,  1'b0, '0}
    };

    localparam int EDGE_CHANNELS = 10;
    localparam logic [CHAN_W-1:0] CHANNEL_EDGES [EDGE_CHANNELS] =
        '{7'd0, 7'd11, 7'd12, 7'd16, 7'd17, 7'd39, 7'd40, 7'd62, 7'd63, 7'd112};

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_stall;
    logic [CHAN_W-1:0]       channel;
    logic signed [OFF_W-1:0] freq_offset;
    logic                    res_valid;
    logic                    res_stall;
    logic                    channel_invalid;
    logic [FREQ_W-1:0]       freq_hz;
    logic [WORD_W-1:0]       tune_word;
    logic                    high_band;

    // Travel alongside the offered word so that the monitor knows which expectation to queue.
    logic    word_typed;
    tuning_t word_known;

    tuning_t pending_tunings [$];
    int      failures;
    int      words_sent;
    int      results_seen;
    int      invalid_seen;
    int      high_band_seen;
    bit      calm;
    bit      hold_request;

    channel_to_tuning_word_core #(
        .MAX_CHANNEL     (MAX_CHANNEL)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .channel         (channel),
        .freq_offset     (freq_offset),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .channel_invalid (channel_invalid),
        .freq_hz         (freq_hz),
        .tune_word       (tune_word),
        .high_band       (high_band)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("tb_channel_to_tuning_word_core: done, errors");
        $finish;
    end

    function automatic tuning_t predict_tuning(input logic [CHAN_W-1:0] ch,
                                               input logic signed [OFF_W-1:0] off);
        tuning_t     t;
        longint      hz;
        longint      off_l;
        logic [31:0] word;
        logic [31:0] rest;
        logic [31:0] step;
        t = '0;
        if (ch > MAX_CHANNEL)
        begin
            t.chan_invalid = 1'b1;
            return t;
        end
        off_l = off;
        hz = BASE_HZ + SEVENTH_HZ + CHAN_STEP_HZ * longint'(ch);
        if ((ch >= LOW_BAND_FIRST && ch <= LOW_BAND_LAST) || ch > UPPER_CHANNEL)
            hz += BAND_EXTRA_HZ;
        // Signed division truncates toward zero, as the offset term requires.
        hz += (off_l * MHZ_HZ) / 7;
        t.freq_hz = FREQ_W'(hz);
        word = 32'(t.freq_hz / MHZ_HZ);
        rest = 32'(t.freq_hz % MHZ_HZ);
        step = 32'(MHZ_HZ);
        repeat (FRAC_BITS)
        begin
            word = word << 1;
            step = step >> 1;
            if (rest > step)
            begin
                rest -= step;
                word += 1;
            end
        end
        if (rest > ROUND_HZ)
            word += 1;
        t.tune_word = word[WORD_W-1:0];
        t.high_band = (t.freq_hz >= HIGH_BAND_HZ);
        return t;
    endfunction

    task automatic compare_field(input string name, input longint expected, input longint actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            failures++;
        end
    endtask

    // Queues the expectation of each accepted word and checks each delivered result.
    always @(posedge clk)
    begin
        tuning_t oldest;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                pending_tunings.push_back(word_typed ? word_known
                                                     : predict_tuning(channel, freq_offset));
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (channel_invalid)
                    invalid_seen++;
                if (high_band)
                    high_band_seen++;
                if (pending_tunings.size() == 0)
                begin
                    $error("result delivered with no word outstanding");
                    failures++;
                end
                else
                begin
                    oldest = pending_tunings.pop_front();
                    compare_field("channel_invalid", longint'(oldest.chan_invalid),
                                  longint'(channel_invalid));
                    compare_field("freq_hz", longint'(oldest.freq_hz), longint'(freq_hz));
                    compare_field("tune_word", longint'(oldest.tune_word), longint'(tune_word));
                    compare_field("high_band", longint'(oldest.high_band), longint'(high_band));
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold when the sender asks for it.
    initial
    begin
        int stall_len;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_len = 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_len = LONG_HOLD;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
                stall_len = $urandom_range(1, 19);
            if (stall_len != 0)
            begin
                res_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                res_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    task automatic offer_word(input logic [CHAN_W-1:0] ch, input logic signed [OFF_W-1:0] off,
                              input logic typed, input tuning_t known);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        channel     <= ch;
        freq_offset <= off;
        word_typed  <= typed;
        word_known  <= known;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        int cycles;
        cycles = 0;
        @(posedge clk);
        while (pending_tunings.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
    endtask

    initial
    begin
        logic [CHAN_W-1:0]       ch;
        logic signed [OFF_W-1:0] off;
        int                      pick;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        channel     = '0;
        freq_offset = '0;
        word_typed  = 1'b0;
        word_known  = '0;
        failures    = 0;
        calm        = 1'b0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            offer_word(DIRECTED[i].ch, DIRECTED[i].off, DIRECTED[i].typed, DIRECTED[i].known);
        req_valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 500)
            begin
                // Keep offering words while the result side holds off, so the pipe fills.
                calm = 1'b1;
                hold_request = 1'b1;
            end
            if (i == 560)
                calm = 1'b0;
            if (i == 800)
            begin
                req_valid <= 1'b0;
                wait_drained();
            end
            if (i == RANDOM_WORDS - 150)
                calm = 1'b1;

            pick = $urandom_range(0, 9);
            if (pick == 0)
                ch = CHAN_W'($urandom_range(MAX_CHANNEL + 1, (1 << CHAN_W) - 1));
            else if (pick == 1)
                ch = CHANNEL_EDGES[$urandom_range(0, EDGE_CHANNELS - 1)];
            else
                ch = CHAN_W'($urandom_range(0, MAX_CHANNEL));
            off = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
            offer_word(ch, off, 1'b0, '0);
        end
        req_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        if (pending_tunings.size() != 0)
        begin
            $error("%0d results never delivered", pending_tunings.size());
            failures++;
        end
        $display("Sent %0d words, checked %0d results: %0d invalid channels, %0d high-band.",
                 words_sent, results_seen, invalid_seen, high_band_seen);
        $display("Run included a long output hold with a full pipe and a full drain pause.");
        if (failures == 0)
            $display("tb_channel_to_tuning_word_core: done, clean");
        else
            $display("tb_channel_to_tuning_word_core: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
